// ===== sv/htc_pkg.sv =====
// Package for the hierarchical transform composer.
// Holds field widths, fixed-point constants, the CORDIC arctangent table and shared types.
// No dependencies.
`default_nettype none
package htc_pkg;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ITER_W = $clog2(CORDIC_ITERATIONS + 1);

    localparam logic [15:0] ONE_ALPHA = 16'd32768;
    localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
    localparam logic signed [33:0] DEG360 = 34'sd23592960;
    localparam logic signed [33:0] DEG180 = 34'sd11796480;
    localparam logic signed [33:0] DEG90  = 34'sd5898240;

    // 92 full turns, enough to lift any 32-bit angle above zero.
    localparam logic signed [33:0] ANGLE_BIAS = 34'sd2170552320;
    // A full turn is 45 * 2^19 in Q16.16 degrees; the reciprocal is 2^20 / 45 rounded up.
    localparam logic [13:0] TURN_HI = 14'd45;
    localparam logic [14:0] RECIP_TURN_HI = 15'd23302;

    typedef struct packed {
        logic        mode;
        logic        last;
        logic [15:0] alpha;
        logic signed [23:0] hscale;
        logic signed [23:0] vscale;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle;
    } in_word_t;

    typedef struct packed {
        logic [15:0] alpha;
        logic signed [23:0] hscale;
        logic signed [23:0] vscale;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic alpha_step;
        logic scale_step;
        logic reduce_quot;
        logic reduce_step;
        logic cordic_init;
        logic cordic_step;
        logic rot_mul;
        logic rot_sum;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic mode;
        logic last;
        logic alpha_zero;
        logic angle_zero;
        logic cordic_done;
    } dp_stat_t;

    function automatic logic signed [23:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:  atan_deg = 24'sd2949120;
            5'd1:  atan_deg = 24'sd1740967;
            5'd2:  atan_deg = 24'sd919879;
            5'd3:  atan_deg = 24'sd466945;
            5'd4:  atan_deg = 24'sd234379;
            5'd5:  atan_deg = 24'sd117304;
            5'd6:  atan_deg = 24'sd58666;
            5'd7:  atan_deg = 24'sd29335;
            5'd8:  atan_deg = 24'sd14668;
            5'd9:  atan_deg = 24'sd7334;
            5'd10: atan_deg = 24'sd3667;
            5'd11: atan_deg = 24'sd1833;
            5'd12: atan_deg = 24'sd917;
            5'd13: atan_deg = 24'sd458;
            5'd14: atan_deg = 24'sd229;
            5'd15: atan_deg = 24'sd115;
            5'd16: atan_deg = 24'sd57;
            5'd17: atan_deg = 24'sd29;
            5'd18: atan_deg = 24'sd14;
            5'd19: atan_deg = 24'sd7;
            5'd20: atan_deg = 24'sd4;
            5'd21: atan_deg = 24'sd2;
            5'd22: atan_deg = 24'sd1;
            default: atan_deg = 24'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== sv/htc_stream_if.sv =====
// Valid/ready channel interface carrying one word of a given packed type.
// The word type is given as a parameter; the interface itself references no package.
`default_nettype none
interface htc_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/hierarchical_transform_compose.sv =====
// Top level of the hierarchical transform composer.
// Depends on htc_pkg, htc_stream_if, htc_ctrl and htc_datapath.
// One word at a time: a sprite word is loaded straight into the accumulator; an ancestor
// word stops after the alpha step when alpha becomes zero, skips the rotation when its
// angle is zero, and otherwise goes through an angle reduction (quotient, then
// remainder), the shared CORDIC stage, a rotation multiply and a rotation sum. A word
// marked last waits in its final state while the output register still holds an
// untaken result. Results sit in an output register, so the next word is taken
// while a result waits.
`default_nettype none
module hierarchical_transform_compose (
    input  wire logic clk,
    input  wire logic rst_n,
    htc_stream_if.sink   in_ch,
    htc_stream_if.source out_ch
);
    htc_pkg::dp_cmd_t   cmd;
    htc_pkg::dp_stat_t  stat;
    htc_pkg::out_word_t acc;
    htc_pkg::out_word_t out_reg;
    logic               out_load;

    htc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .out_load  (out_load)
    );

    htc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_ch.data),
        .cmd     (cmd),
        .stat    (stat),
        .acc     (acc)
    );

    always_ff @(posedge clk)
    begin
        if (out_load) out_reg <= acc;
    end
    assign out_ch.data = out_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result word changed while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ch.ready)
        else $error("input taken while busy");
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.alpha <= htc_pkg::ONE_ALPHA)
        else $error("alpha above one");
`endif
endmodule
`default_nettype wire

// ===== sv/htc_datapath.sv =====
// Datapath of the transform composer: accumulator, multipliers, angle reduction, CORDIC.
// Depends on htc_pkg; driven by htc_ctrl through command and status structs.
`default_nettype none
module htc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  htc_pkg::in_word_t        in_word,
    input  htc_pkg::dp_cmd_t         cmd,
    output htc_pkg::dp_stat_t        stat,
    output htc_pkg::out_word_t       acc
);
    htc_pkg::in_word_t  item_reg;
    logic [15:0]        acc_alpha_reg;
    logic signed [23:0] acc_hs_reg, acc_vs_reg;
    logic signed [31:0] acc_px_reg, acc_py_reg, acc_an_reg;
    logic signed [33:0] r_reg;
    logic [8:0]         quot_reg;
    logic               neg_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic [htc_pkg::ITER_W-1:0] iter_reg;
    logic signed [63:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;

    logic [15:0]        alpha_clip;
    logic [31:0]        alpha_prod;
    logic signed [47:0] hs_prod, vs_prod;
    logic signed [55:0] px_prod, py_prod;
    logic signed [33:0] an_ext, r_mod, r_wrap, r_fold;
    logic [28:0]        quot_prod;
    logic [13:0]        rem_hi;
    logic               fold_neg;
    logic signed [31:0] dx, dy, cos_v, sin_v;
    logic signed [23:0] atan_v;
    logic signed [65:0] sum_x, sum_y;
    logic signed [32:0] add_x, add_y, add_a;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) sat24 = 24'sh7fffff;
        else if (v < -48'sd8388608) sat24 = 24'sh800000;
        else sat24 = v[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    assign alpha_clip = (item_reg.alpha > htc_pkg::ONE_ALPHA) ? htc_pkg::ONE_ALPHA
                                                              : item_reg.alpha;
    assign alpha_prod = acc_alpha_reg * alpha_clip;
    assign hs_prod = acc_hs_reg * item_reg.hscale + 48'sd32768;
    assign vs_prod = acc_vs_reg * item_reg.vscale + 48'sd32768;
    assign px_prod = acc_px_reg * item_reg.hscale + 56'sd32768;
    assign py_prod = acc_py_reg * item_reg.vscale + 56'sd32768;

    // Angle reduction: the biased angle is nonnegative, and a full turn is 45 * 2^19,
    // so only bits 32..19 need a remainder by 45. The quotient comes from a reciprocal
    // multiply and is registered; the remainder is formed from it in the next cycle.
    assign an_ext = 34'(item_reg.angle);
    assign quot_prod = r_reg[32:19] * htc_pkg::RECIP_TURN_HI;
    assign rem_hi = r_reg[32:19] - 14'(quot_reg) * htc_pkg::TURN_HI;
    assign r_mod = {1'b0, rem_hi, r_reg[18:0]};

    always_comb
    begin
        r_wrap = (r_reg >= htc_pkg::DEG180) ? r_reg - htc_pkg::DEG360 : r_reg;
        fold_neg = 1'b0;
        r_fold = r_wrap;
        if (r_wrap > htc_pkg::DEG90)
        begin
            r_fold = r_wrap - htc_pkg::DEG180;
            fold_neg = 1'b1;
        end
        else if (r_wrap < -htc_pkg::DEG90)
        begin
            r_fold = r_wrap + htc_pkg::DEG180;
            fold_neg = 1'b1;
        end
    end

    assign dx = cy_reg >>> iter_reg;
    assign dy = cx_reg >>> iter_reg;
    assign atan_v = htc_pkg::atan_deg(5'(iter_reg));
    assign cos_v = neg_reg ? -cx_reg : cx_reg;
    assign sin_v = neg_reg ? -cy_reg : cy_reg;
    assign sum_x = 66'(p_xc_reg) - 66'(p_ys_reg) + 66'sd536870912;
    assign sum_y = 66'(p_xs_reg) + 66'(p_yc_reg) + 66'sd536870912;
    assign add_x = 33'(acc_px_reg) + 33'(item_reg.pos_x);
    assign add_y = 33'(acc_py_reg) + 33'(item_reg.pos_y);
    assign add_a = 33'(acc_an_reg) + 33'(item_reg.angle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            acc_alpha_reg <= '0;
            acc_hs_reg <= '0;
            acc_vs_reg <= '0;
            acc_px_reg <= '0;
            acc_py_reg <= '0;
            acc_an_reg <= '0;
            r_reg <= '0;
            quot_reg <= '0;
            neg_reg <= 1'b0;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            iter_reg <= '0;
            p_xc_reg <= '0;
            p_ys_reg <= '0;
            p_xs_reg <= '0;
            p_yc_reg <= '0;
        end
        else
        begin
            if (cmd.capture) item_reg <= in_word;
            if (cmd.load)
            begin
                acc_alpha_reg <= alpha_clip;
                acc_hs_reg <= item_reg.hscale;
                acc_vs_reg <= item_reg.vscale;
                acc_px_reg <= item_reg.pos_x;
                acc_py_reg <= item_reg.pos_y;
                acc_an_reg <= item_reg.angle;
            end
            if (cmd.alpha_step)
            begin
                acc_alpha_reg <= alpha_prod[30:15];
                r_reg <= an_ext + htc_pkg::ANGLE_BIAS;
            end
            if (cmd.scale_step)
            begin
                acc_hs_reg <= sat24(hs_prod >>> 16);
                acc_vs_reg <= sat24(vs_prod >>> 16);
                acc_px_reg <= sat32(66'(px_prod >>> 16));
                acc_py_reg <= sat32(66'(py_prod >>> 16));
            end
            if (cmd.reduce_quot) quot_reg <= quot_prod[28:20];
            if (cmd.reduce_step) r_reg <= r_mod;
            if (cmd.cordic_init)
            begin
                cz_reg <= r_fold;
                neg_reg <= fold_neg;
                cx_reg <= htc_pkg::CORDIC_K;
                cy_reg <= 32'sd0;
                iter_reg <= '0;
            end
            if (cmd.cordic_step)
            begin
                if (cz_reg >= 34'sd0)
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - 34'(atan_v);
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + 34'(atan_v);
                end
                iter_reg <= iter_reg + 1'b1;
            end
            if (cmd.rot_mul)
            begin
                p_xc_reg <= acc_px_reg * cos_v;
                p_ys_reg <= acc_py_reg * sin_v;
                p_xs_reg <= acc_px_reg * sin_v;
                p_yc_reg <= acc_py_reg * cos_v;
            end
            if (cmd.rot_sum)
            begin
                acc_px_reg <= sat32(sum_x >>> 30);
                acc_py_reg <= sat32(sum_y >>> 30);
            end
            if (cmd.finish)
            begin
                acc_px_reg <= sat32(66'(add_x));
                acc_py_reg <= sat32(66'(add_y));
                acc_an_reg <= sat32(66'(add_a));
            end
        end
    end

    assign stat.mode = item_reg.mode;
    assign stat.last = item_reg.last;
    assign stat.alpha_zero = (acc_alpha_reg == 16'd0);
    assign stat.angle_zero = (item_reg.angle == 32'sd0);
    assign stat.cordic_done = (iter_reg == htc_pkg::ITER_W'(htc_pkg::CORDIC_ITERATIONS));

    assign acc.alpha = acc_alpha_reg;
    assign acc.hscale = acc_hs_reg;
    assign acc.vscale = acc_vs_reg;
    assign acc.pos_x = acc_px_reg;
    assign acc.pos_y = acc_py_reg;
    assign acc.angle = acc_an_reg;
endmodule
`default_nettype wire

// ===== sv/htc_ctrl.sv =====
// Controller state machine of the transform composer.
// Depends on htc_pkg; sequences htc_datapath and owns the input and output handshakes.
`default_nettype none
module htc_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  htc_pkg::dp_stat_t stat,
    output htc_pkg::dp_cmd_t  cmd,
    output logic              out_load
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_ALPHA  = 4'd2;
    localparam logic [3:0] S_SCALE  = 4'd3;
    localparam logic [3:0] S_REDUCE = 4'd4;
    localparam logic [3:0] S_INIT   = 4'd5;
    localparam logic [3:0] S_CORDIC = 4'd6;
    localparam logic [3:0] S_RMUL   = 4'd7;
    localparam logic [3:0] S_RSUM   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // The output register frees the input side as soon as the word is loaded.
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        out_load = 1'b0;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid) state_next = S_DISP;
            end
            S_DISP:
            begin
                if (!stat.mode)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.alpha_step = 1'b1;
                    state_next = S_ALPHA;
                end
            end
            S_ALPHA:
            begin
                if (stat.alpha_zero) state_next = S_EMIT;
                else
                begin
                    cmd.scale_step = 1'b1;
                    cmd.reduce_quot = 1'b1;
                    state_next = stat.angle_zero ? S_FIN : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                if (stat.cordic_done) state_next = S_RMUL;
                else cmd.cordic_step = 1'b1;
            end
            S_RMUL:
            begin
                cmd.rot_mul = 1'b1;
                state_next = S_RSUM;
            end
            S_RSUM:
            begin
                cmd.rot_sum = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.last) state_next = S_IDLE;
                else if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/hierarchical_transform_compose_test.sv =====
// Self-checking testbench for the hierarchical transform composer.
// Depends on htc_pkg, htc_stream_if and the hierarchical_transform_compose RTL.
// Sprite and ancestor chains are streamed in, and each composed transform is checked.
module hierarchical_transform_compose_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FULL_TURN = 64'sd23592960;
    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint QUARTER_TURN = 64'sd5898240;
    localparam longint GAIN_START = 64'sd652032874;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    class transform_scoreboard;
        logic [15:0] opacity;
        longint sx, sy, px, py, rot;
        htc_pkg::out_word_t composed_q[$];
        int errors;
        int results;

        function new();
            opacity = 0;
            sx = 0; sy = 0; px = 0; py = 0; rot = 0;
            errors = 0;
            results = 0;
        endfunction

        function longint clamp(longint v, int w);
            longint hi, lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint fix_mul(longint a, longint b, int w);
            return clamp((a * b + 32768) >>> 16, w);
        endfunction

        // Degree-domain CORDIC; the angle is folded into [-90,90] first.
        function void sin_cos(longint ang, output longint c, output longint s);
            longint r, x, y, z, dx, dy;
            bit flip;
            r = ang % FULL_TURN;
            flip = 0;
            if (r < 0) r += FULL_TURN;
            if (r >= HALF_TURN) r -= FULL_TURN;
            if (r > QUARTER_TURN)
            begin
                r -= HALF_TURN;
                flip = 1;
            end
            else if (r < -QUARTER_TURN)
            begin
                r += HALF_TURN;
                flip = 1;
            end
            x = GAIN_START;
            y = 0;
            z = r;
            for (int i = 0; i < htc_pkg::CORDIC_ITERATIONS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= htc_pkg::atan_deg(5'(i));
                end
                else
                begin
                    x += dx; y -= dy; z += htc_pkg::atan_deg(5'(i));
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_input(htc_pkg::in_word_t w);
            logic [15:0] a;
            longint ang, c, s, nx, ny;
            htc_pkg::out_word_t e;
            a = (w.alpha > htc_pkg::ONE_ALPHA) ? htc_pkg::ONE_ALPHA : w.alpha;
            ang = longint'(w.angle);
            if (!w.mode)
            begin
                opacity = a;
                sx = longint'(w.hscale); sy = longint'(w.vscale);
                px = longint'(w.pos_x); py = longint'(w.pos_y); rot = ang;
            end
            else
            begin
                opacity = 16'((32'(opacity) * 32'(a)) >> 15);
                if (opacity != 0)
                begin
                    sx = fix_mul(sx, longint'(w.hscale), 24);
                    sy = fix_mul(sy, longint'(w.vscale), 24);
                    px = fix_mul(px, longint'(w.hscale), 32);
                    py = fix_mul(py, longint'(w.vscale), 32);
                    if (ang != 0)
                    begin
                        sin_cos(ang, c, s);
                        nx = (px * c - py * s + (64'sd1 <<< 29)) >>> 30;
                        ny = (px * s + py * c + (64'sd1 <<< 29)) >>> 30;
                        px = clamp(nx, 32);
                        py = clamp(ny, 32);
                    end
                    px = clamp(px + longint'(w.pos_x), 32);
                    py = clamp(py + longint'(w.pos_y), 32);
                    rot = clamp(rot + ang, 32);
                end
            end
            if (w.last)
            begin
                e.alpha = opacity;
                e.hscale = sx[23:0]; e.vscale = sy[23:0];
                e.pos_x = px[31:0]; e.pos_y = py[31:0]; e.angle = rot[31:0];
                composed_q.push_back(e);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("result %0d: %s got %0d, expected %0d", results, what, got, want);
            errors++;
        endtask

        task check_result(htc_pkg::out_word_t r);
            htc_pkg::out_word_t e;
            results++;
            if (composed_q.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            e = composed_q.pop_front();
            if (r.alpha !== e.alpha) report("alpha", r.alpha, e.alpha);
            if (r.hscale !== e.hscale) report("hscale", r.hscale, e.hscale);
            if (r.vscale !== e.vscale) report("vscale", r.vscale, e.vscale);
            if (r.pos_x !== e.pos_x) report("pos_x", r.pos_x, e.pos_x);
            if (r.pos_y !== e.pos_y) report("pos_y", r.pos_y, e.pos_y);
            if (r.angle !== e.angle) report("angle", r.angle, e.angle);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    htc_stream_if #(.word_t(htc_pkg::in_word_t)) in_ch();
    htc_stream_if #(.word_t(htc_pkg::out_word_t)) out_ch();

    hierarchical_transform_compose u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    transform_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int idle_odds = 6;
    int sent = 0;
    int chains = 0;
    int rotations = 0;
    int quiet_cycles = 0;

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("hierarchical_transform_compose: mismatch");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 0;
            end
            else if (quiet)
                out_ch.ready <= 1;
            else if (burst > 0)
            begin
                out_ch.ready <= 0;
                burst--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 0;
                burst = $urandom_range(0, 4);
            end
            else
                out_ch.ready <= 1;
        end
    end

    task automatic send_word(htc_pkg::in_word_t w);
        int gap;
        if (!quiet && idle_odds > 0 && $urandom_range(0, idle_odds) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_ch.valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1;
        in_ch.data <= w;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(w);
        sent++;
        if (w.mode && w.angle != 0) rotations++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 0;
        while (sb.composed_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic htc_pkg::in_word_t build(bit m, bit l, logic [15:0] a, longint hs,
                                                longint vs, longint x, longint y,
                                                longint an);
        htc_pkg::in_word_t w;
        w.mode = m; w.last = l; w.alpha = a;
        w.hscale = hs[23:0]; w.vscale = vs[23:0];
        w.pos_x = x[31:0]; w.pos_y = y[31:0]; w.angle = an[31:0];
        return w;
    endfunction

    function automatic htc_pkg::in_word_t random_word(bit m, bit l);
        htc_pkg::in_word_t w;
        w.mode = m;
        w.last = l;
        case ($urandom_range(0, 5))
            0, 1: w.alpha = htc_pkg::ONE_ALPHA;
            2: w.alpha = 16'($urandom);
            3: w.alpha = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            default: w.alpha = 16'($urandom_range(16384, 32768));
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            w.hscale = 24'($urandom);
            w.vscale = 24'($urandom);
        end
        else
        begin
            w.hscale = 24'($signed($urandom_range(0, 524288)) - 262144);
            w.vscale = 24'($signed($urandom_range(0, 524288)) - 262144);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            w.pos_x = $urandom;
            w.pos_y = $urandom;
        end
        else
        begin
            w.pos_x = 32'($signed($urandom_range(0, 131072000)) - 65536000);
            w.pos_y = 32'($signed($urandom_range(0, 131072000)) - 65536000);
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: w.angle = 0;
            7, 8, 9, 10, 11: w.angle = $urandom;
            12, 13: w.angle = 32'(($signed($urandom_range(0, 8)) - 4) * 5898240);
            default: w.angle = 32'($signed($urandom_range(0, 94371840)) - 47185920);
        endcase
        return w;
    endfunction

    initial
    begin
        htc_pkg::in_word_t dir[$];
        int depth;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Ancestor before any sprite, then a sprite emitted with only its alpha clipped to one.
        dir.push_back(build(1, 1, htc_pkg::ONE_ALPHA, 65536, 65536, 100, 200, 5898240));
        dir.push_back(build(0, 1, 16'hFFFF, -8388608, 8388607, -2147483648, 2147483647,
                            -2147483648));
        dir.push_back(build(0, 0, htc_pkg::ONE_ALPHA, 65536, 65536, 655360, 0, 0));
        dir.push_back(build(1, 0, htc_pkg::ONE_ALPHA, 131072, 65536, 65536, 65536, 5898240));
        dir.push_back(build(1, 0, 16'd40000, 65536, -65536, 0, 0, 11796480));
        dir.push_back(build(1, 0, htc_pkg::ONE_ALPHA, 65536, 65536, 0, 0, -5898240));
        dir.push_back(build(1, 0, htc_pkg::ONE_ALPHA, 65536, 65536, 0, 0, 17694720));
        dir.push_back(build(1, 1, htc_pkg::ONE_ALPHA, 65536, 65536, 0, 0, 2147483647));
        // Saturation of scales, positions and angle.
        dir.push_back(build(0, 0, htc_pkg::ONE_ALPHA, 8388607, -8388608, 2147483647,
                            -2147483648, 2147483647));
        dir.push_back(build(1, 0, htc_pkg::ONE_ALPHA, 8388607, 8388607, 2147483647,
                            -2147483648, 2147483647));
        dir.push_back(build(1, 1, htc_pkg::ONE_ALPHA, -8388608, -8388608, 2147483647,
                            2147483647, -2147483648));
        // Alpha collapses to zero; later ancestors change nothing.
        dir.push_back(build(0, 0, 16'd1, 65536, 65536, 1000, 1000, 100));
        dir.push_back(build(1, 0, 16'd16384, 131072, 131072, 5, 5, 5898240));
        dir.push_back(build(1, 1, htc_pkg::ONE_ALPHA, 131072, 131072, 5, 5, 5898240));
        dir.push_back(build(0, 0, 16'd0, 65536, 65536, 7, 7, 0));
        dir.push_back(build(1, 1, htc_pkg::ONE_ALPHA, 65536, 65536, 7, 7, 0));
        dir.push_back(build(0, 0, htc_pkg::ONE_ALPHA, 0, 0, 0, 0, 0));
        dir.push_back(build(1, 1, 16'd32767, 0, 0, 0, 0, -1));
        foreach (dir[i]) send_word(dir[i]);
        drain();

        while (sent < 1450)
        begin
            if (sent > 1300) quiet = 1;
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            if (chains == 40) hold_req = 1;
            if (chains == 120) drain();
            if ($urandom_range(0, 9) == 0)
            begin
                // Loose words: arbitrary mode and last bits.
                send_word(random_word($urandom_range(0, 1), $urandom_range(0, 1)));
            end
            else
            begin
                depth = $urandom_range(0, 4);
                send_word(random_word(0, depth == 0));
                for (int k = 1; k <= depth; k++)
                    send_word(random_word(1, k == depth));
                chains++;
            end
        end
        drain();

        $display("Sent %0d words in %0d chains, %0d of them rotating ancestors.",
                 sent, chains, rotations);
        $display("Checked %0d composed transforms, %0d field errors.", sb.results, sb.errors);
        if (sb.errors == 0 && sb.composed_q.size() == 0)
            $display("hierarchical_transform_compose: match");
        else
            $display("hierarchical_transform_compose: mismatch");
        $finish;
    end
endmodule
